// File: rtl/cpa_pkg.sv
package cpa_pkg;

	localparam int NUM_PAGES   = 4096;
	localparam int MAX_RUN     = 64;
	localparam int PG_OFS_BITS = 12;
	localparam int PAGE_BYTES  = 1 << PG_OFS_BITS;
	localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
	localparam int RUN_W       = $clog2(MAX_RUN + 1);
	localparam int WORD_W      = 64;
	localparam int OFS_W       = $clog2(WORD_W);
	localparam int NUM_WORDS   = NUM_PAGES / WORD_W;
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int WIN_W       = 2 * WORD_W;
	localparam int LVL_N       = $clog2(MAX_RUN) + 1;
	localparam int LVL_W       = $clog2(LVL_N);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 72;
	localparam int ADDR_W      = 32;
	localparam int VADDR_W     = 64;
	localparam int BYTES_W     = 19;
	localparam int FREE_PG_W   = 7;

	// request kinds carried in s_tuser
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// register select, taken from paddr[3]
	localparam logic REG_MEMORY_BASE    = 1'b0;
	localparam logic REG_VIRTUAL_OFFSET = 1'b1;

	localparam logic [ADDR_W-1:0] MEMORY_BASE_RST = 32'h0040_0000;

	typedef enum logic [1:0] {
		CMD_DONE,
		CMD_ALLOC,
		CMD_FREE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  ok;
		logic [RUN_W-1:0]      need;
		logic [PAGE_IDX_W-1:0] lo;
		logic [PAGE_IDX_W-1:0] last;
	} cpa_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK_HI,
		ST_MARK_LO,
		ST_ADDR,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_RESULT
	} back_state_t;

endpackage

// File: rtl/cpa_front.sv
module cpa_front import cpa_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic [ADDR_W-1:0]    memory_base,
	input  logic                 q_full,
	output logic                 q_push,
	output cpa_cmd_t             q_din
);

	logic [BYTES_W-1:0]   byte_count;
	logic [ADDR_W-1:0]    free_addr;
	logic [FREE_PG_W-1:0] free_pages;
	logic [BYTES_W:0]     bytes_up;
	logic [BYTES_W-PG_OFS_BITS:0] need;
	logic [ADDR_W-1:0]    offs;
	logic [ADDR_W-PG_OFS_BITS-1:0] first_pg;
	logic [ADDR_W-PG_OFS_BITS:0]   hi_pg;
	logic                 hi_ok;

	assign byte_count = s_tdata[BYTES_W-1:0];
	assign free_addr  = s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
	assign free_pages = s_tdata[BYTES_W+ADDR_W+FREE_PG_W-1:BYTES_W+ADDR_W];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// round the byte count up to whole pages
	assign bytes_up = {1'b0, byte_count} + (BYTES_W+1)'(PAGE_BYTES - 1);
	assign need     = bytes_up[BYTES_W:PG_OFS_BITS];

	assign offs     = free_addr - memory_base;
	assign first_pg = offs[ADDR_W-1:PG_OFS_BITS];
	assign hi_pg    = {1'b0, first_pg} + (ADDR_W-PG_OFS_BITS+1)'(free_pages);
	assign hi_ok    = hi_pg <= (ADDR_W-PG_OFS_BITS+1)'(NUM_PAGES);

	always_comb begin
		q_din.kind = CMD_DONE;
		q_din.ok   = 1'b0;
		q_din.need = '0;
		q_din.lo   = '0;
		q_din.last = '0;
		case (s_tuser)
			REQ_ALLOC: begin
				if (need != '0 && need <= (BYTES_W-PG_OFS_BITS+1)'(MAX_RUN)) begin
					q_din.kind = CMD_ALLOC;
					q_din.need = need[RUN_W-1:0];
				end
			end
			REQ_FREE: begin
				if (free_pages == '0) begin
					q_din.ok = 1'b1;
				end else if (free_addr >= memory_base &&
						first_pg < (ADDR_W-PG_OFS_BITS)'(NUM_PAGES)) begin
					// pages past the end of the map are dropped and flagged
					q_din.kind = CMD_FREE;
					q_din.ok   = hi_ok;
					q_din.lo   = first_pg[PAGE_IDX_W-1:0];
					q_din.last = hi_ok ? PAGE_IDX_W'(hi_pg - 1'b1)
						: PAGE_IDX_W'(NUM_PAGES - 1);
				end
			end
			default: begin
				q_din.kind = CMD_DONE;
			end
		endcase
	end

endmodule

// File: rtl/cpa_queue.sv
module cpa_queue import cpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cpa_cmd_t din,
	input  logic     pop,
	output cpa_cmd_t dout,
	output logic     full,
	output logic     empty
);

	cpa_cmd_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: rtl/cpa_back.sv
module cpa_back import cpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpa_cmd_t              cmd,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  logic [ADDR_W-1:0]     memory_base,
	input  logic [VADDR_W-1:0]    virtual_offset,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	back_state_t state_q, state_d;

	// page map, one bit per page, 64 pages per row
	logic [WORD_W-1:0]     map_mem [NUM_WORDS];
	logic [NUM_WORDS-1:0]  row_valid_q;

	logic                  mem_re, mem_we;
	logic [WORD_IDX_W-1:0] mem_raddr, mem_waddr;
	logic [WORD_W-1:0]     mem_wdata;

	logic [RUN_W-1:0]      need_q;
	logic [PAGE_IDX_W-1:0] lo_q, last_q;
	logic                  res_ok_q, alloc_ok_q;
	logic [WORD_IDX_W:0]   iss_q;
	logic [WORD_IDX_W-1:0] fw_q;

	logic [WORD_W-1:0]     rd_word_s1;
	logic                  rd_rowv_s1;
	logic [WORD_IDX_W-1:0] rd_idx_s1;
	logic                  rd_v_s1;
	logic [WORD_W-1:0]     word_s1;
	logic [WORD_W-1:0]     prev_q;

	logic [WIN_W-1:0]      hl_s2;
	logic [WORD_W-1:0]     cur_s2, prv_s2;
	logic [WORD_IDX_W-1:0] idx_s2;
	logic                  v_s2;

	logic [WORD_IDX_W-1:0] hit_word_q;
	logic [WORD_W-1:0]     new_hi_q, new_lo_q;
	logic                  lo_touch_q;
	logic [PAGE_IDX_W-1:0] start_page_q;
	logic [ADDR_W:0]       phys_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [LVL_W-1:0]      lvl;
	logic [RUN_W-1:0]      run_gap;
	logic [WIN_W-1:0]      runs [LVL_N];
	logic [WIN_W-1:0]      hl_d;
	logic [WIN_W-1:0]      ends;
	logic [WORD_W-1:0]     hit_vec;
	logic                  hit_any;
	logic [OFS_W-1:0]      hit_pos;
	logic [RUN_W-1:0]      end_k, start_k;
	logic [WORD_W-1:0]     need_mask;
	logic [WIN_W-1:0]      win_mask;
	logic [PAGE_IDX_W:0]   start_sum;
	logic                  scan_re, scan_fail;
	logic [RUN_W-1:0]      lo_in, hi_in;
	logic [WORD_W-1:0]     clr_mask;
	logic                  out_load;
	logic [VADDR_W-1:0]    res_addr;
	logic [RUN_W-1:0]      res_cnt;

	assign word_s1 = rd_rowv_s1 ? rd_word_s1 : '0;

	// split the run length into two overlapping power-of-two runs
	always_comb begin
		lvl = '0;
		for (int b = 0; b < LVL_N; b++) begin
			if (need_q[b]) begin
				lvl = LVL_W'(b);
			end
		end
	end
	assign run_gap = need_q - (RUN_W'(1) << lvl);

	// runs[b] bit k: pages k-2^b+1 .. k of the two-row window are all free
	always_comb begin
		runs[0] = ~{word_s1, prev_q};
		for (int b = 1; b < LVL_N; b++) begin
			runs[b] = runs[b-1] & (runs[b-1] << (1 << (b-1)));
		end
	end
	assign hl_d = runs[lvl];

	assign ends    = hl_s2 & (hl_s2 << run_gap);
	assign hit_vec = ends[WIN_W-1:WORD_W];
	assign hit_any = v_s2 && (|hit_vec);

	always_comb begin
		hit_pos = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				hit_pos = OFS_W'(k);
			end
		end
	end

	assign end_k     = {1'b1, hit_pos};
	assign start_k   = end_k + RUN_W'(1) - need_q;
	assign need_mask = ~({WORD_W{1'b1}} << need_q);
	assign win_mask  = {{WORD_W{1'b0}}, need_mask} << start_k;
	assign start_sum = (PAGE_IDX_W+1)'({idx_s2, {OFS_W{1'b0}}})
		+ (PAGE_IDX_W+1)'(start_k) - (PAGE_IDX_W+1)'(WORD_W);

	assign scan_re   = state_q == ST_SCAN && iss_q < (WORD_IDX_W+1)'(NUM_WORDS);
	assign scan_fail = v_s2 && !hit_any && idx_s2 == WORD_IDX_W'(NUM_WORDS - 1);

	// bits of the current row that fall inside the freed range
	assign lo_in = (fw_q == lo_q[PAGE_IDX_W-1:OFS_W]) ? RUN_W'(lo_q[OFS_W-1:0]) : '0;
	assign hi_in = (fw_q == last_q[PAGE_IDX_W-1:OFS_W])
		? RUN_W'(last_q[OFS_W-1:0]) + RUN_W'(1) : RUN_W'(WORD_W);
	assign clr_mask = ({WORD_W{1'b1}} << lo_in) & ~({WORD_W{1'b1}} << hi_in);

	assign res_addr = alloc_ok_q ? VADDR_W'(phys_q) + virtual_offset : '0;
	assign res_cnt  = alloc_ok_q ? need_q : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (cmd.kind)
						CMD_ALLOC: state_d = ST_SCAN;
						CMD_FREE:  state_d = ST_FREE_RD;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit_any) begin
					state_d = ST_MARK_HI;
				end else if (scan_fail) begin
					state_d = ST_RESULT;
				end
			end
			ST_MARK_HI: state_d = lo_touch_q ? ST_MARK_LO : ST_ADDR;
			ST_MARK_LO: state_d = ST_ADDR;
			ST_ADDR:    state_d = ST_RESULT;
			ST_FREE_RD: state_d = ST_FREE_WR;
			ST_FREE_WR: begin
				if (fw_q == last_q[PAGE_IDX_W-1:OFS_W]) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_FREE_RD;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = iss_q[WORD_IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = hit_word_q;
		mem_wdata = new_hi_q;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: q_pop = !q_empty;
			ST_SCAN: mem_re = scan_re;
			ST_MARK_HI: mem_we = 1'b1;
			ST_MARK_LO: begin
				mem_we    = 1'b1;
				mem_waddr = hit_word_q - 1'b1;
				mem_wdata = new_lo_q;
			end
			ST_FREE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = fw_q;
			end
			ST_FREE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = fw_q;
				mem_wdata = word_s1 & ~clr_mask;
			end
			ST_RESULT: out_load = !m_tvalid_q || m_tready;
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			iss_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				row_valid_q[mem_waddr] <= 1'b1;
			end
			// squash in-flight rows once a run is found
			rd_v_s1 <= scan_re && !hit_any;
			v_s2    <= rd_v_s1 && state_q == ST_SCAN && !hit_any;
			if (q_pop) begin
				iss_q <= '0;
			end else if (scan_re) begin
				iss_q <= iss_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_word_s1 <= map_mem[mem_raddr];
			rd_rowv_s1 <= row_valid_q[mem_raddr];
			rd_idx_s1  <= mem_raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prev_q <= word_s1;
			hl_s2  <= hl_d;
			cur_s2 <= word_s1;
			prv_s2 <= prev_q;
			idx_s2 <= rd_idx_s1;
		end
		if (state_q == ST_SCAN && hit_any) begin
			new_hi_q     <= cur_s2 | win_mask[WIN_W-1:WORD_W];
			new_lo_q     <= prv_s2 | win_mask[WORD_W-1:0];
			hit_word_q   <= idx_s2;
			lo_touch_q   <= !start_k[RUN_W-1];
			start_page_q <= start_sum[PAGE_IDX_W-1:0];
			res_ok_q     <= 1'b1;
			alloc_ok_q   <= 1'b1;
		end
		if (state_q == ST_ADDR) begin
			phys_q <= (ADDR_W+1)'(memory_base)
				+ (ADDR_W+1)'({start_page_q, {PG_OFS_BITS{1'b0}}});
		end
		if (state_q == ST_FREE_WR) begin
			fw_q <= fw_q + 1'b1;
		end
		if (q_pop) begin
			// the row before row zero counts as fully used
			prev_q     <= '1;
			need_q     <= cmd.need;
			lo_q       <= cmd.lo;
			last_q     <= cmd.last;
			res_ok_q   <= cmd.ok;
			alloc_ok_q <= 1'b0;
			fw_q       <= cmd.lo[PAGE_IDX_W-1:OFS_W];
		end
		if (out_load) begin
			m_tdata_q <= {res_ok_q, res_cnt, res_addr};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: rtl/contiguous_page_allocator_core.sv
// First-fit allocator over a map of 4096 pages of 4 KiB, all free after reset.
// An allocate request (s_tuser 0) rounds byte_count up to 1..64 pages, takes the lowest
// run of that many free pages and returns memory_base + page*4096 + virtual_offset with
// the page count and ok set; with no room, or for a zero or oversized count, it returns
// zeros with ok clear. A free request (s_tuser 1) clears free_pages marks starting at the
// page holding free_addr; pages outside the map are skipped and clear ok. Every request
// gives exactly one result. The map sits in a 64 x 64-bit memory read one row per cycle while
// scanning: an allocate scans rows from row zero until it finds its run, a free reads and writes
// back each touched row (one to three), and a request rejected up front goes straight to its
// result. A two-entry queue takes new requests while the back end is busy. Rows carry valid
// flags, so the block is ready straight out of reset.
module contiguous_page_allocator_core import cpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// byte_count[18:0], free_addr[50:19], free_pages[57:51], zero[63:58]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// start_addr[63:0], page_count[70:64], ok[71]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	logic [ADDR_W-1:0]  memory_base_q;
	logic [VADDR_W-1:0] virtual_offset_q;
	logic               cfg_wr;
	logic               q_push, q_pop, q_full, q_empty;
	cpa_cmd_t           q_din, q_dout;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_base_q    <= MEMORY_BASE_RST;
			virtual_offset_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_MEMORY_BASE:    memory_base_q    <= pwdata[ADDR_W-1:0];
				REG_VIRTUAL_OFFSET: virtual_offset_q <= pwdata;
				default:            virtual_offset_q <= virtual_offset_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_MEMORY_BASE:    prdata = 64'(memory_base_q);
			REG_VIRTUAL_OFFSET: prdata = virtual_offset_q;
			default:            prdata = '0;
		endcase
	end

	cpa_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.memory_base (memory_base_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_din       (q_din)
	);

	cpa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	cpa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (q_dout),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.memory_base    (memory_base_q),
		.virtual_offset (virtual_offset_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

`ifndef ASSERT_OFF
	a_count_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[70:64] != 7'd0 |-> m_tdata[71])
		else $error("page count given without ok");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[71] |-> m_tdata[63:0] == 64'd0 && m_tdata[70:64] == 7'd0)
		else $error("failed result carries a start or count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[70:64] <= 7'(MAX_RUN))
		else $error("page count above the run limit");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("request queue both full and empty");
`endif

endmodule
